[hw/rtl/smk_pkg.sv]
// Shared types and constants for the sorted keyword matcher.
`default_nettype none

package smk_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR_CHARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_LENGTH     = 2'd1;

  localparam int LIST_LEN_W = 5;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 4;
  localparam int SEP_MAX    = 4;

  // Word commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_MATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_CONTINUE    = 2'd0,
    ST_MATCHED     = 2'd1,
    ST_NOT_IN_LIST = 2'd2,
    ST_STRING_END  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/smk_if.sv]
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface smk_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic                         start_req;
  logic [smk_pkg::CHAR_W-1:0]   char_value;
  logic [smk_pkg::IDX_W-1:0]    entry_index;
  logic [smk_pkg::IDX_W-1:0]    char_position;

  modport source (output valid, command, start_req, char_value, entry_index, char_position,
                  input ready);
  modport sink   (input valid, command, start_req, char_value, entry_index, char_position,
                  output ready);
endinterface

interface smk_out_if;
  logic                       valid;
  logic                       ready;
  smk_pkg::status_t           status;
  logic [smk_pkg::IDX_W-1:0]  match_index;

  modport source (output valid, status, match_index, input ready);
  modport sink   (input valid, status, match_index, output ready);
endinterface

`default_nettype wire

[hw/rtl/smk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/sorted_keyword_matcher.sv]
// Top level of the sorted keyword matcher: window sequencer, table RAM and result register.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------------------
//  in_ch    | in  | valid/ready        | command, start_req, char_value, entry_index,
//           |     |                    | char_position
//  out_ch   | out | valid/ready        | status, match_index
//  cfg_*    | in  | cfg_we, no wait    | cfg_index, cfg_wdata (32 bits)
//
//  A load word writes one table byte when entry and position are in range; it gives no result.
//  A match word scans the window one entry at a time: S_RD addresses the entry's byte and
//  S_CMP compares it; a scan that runs off the end of the window passes S_RD once more
//  before S_OUT. A NUL character or a full position goes straight to S_OUT.
//  rst_n (synchronous, active low) clears window, position, registers and the output valid;
//  the table is not cleared. A stalled result holds in the output register while the next word
//  is accepted; the sequencer then waits in its output state until the slot frees.
`default_nettype none

module sorted_keyword_matcher #(
  parameter int NUM_ENTRIES = 16,
  parameter int MAX_LEN     = 16,
  parameter int SEP_SLOTS   = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [smk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [smk_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  smk_in_if.sink                                  in_ch,
  smk_out_if.source                               out_ch
);

  import smk_pkg::*;

  localparam int DEPTH = NUM_ENTRIES * MAX_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $clog2(NUM_ENTRIES + 1);
  localparam int PW    = $clog2(MAX_LEN + 1);

  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_LEN);
  localparam logic [EW-1:0] ENTRIES_E  = EW'(NUM_ENTRIES);
  localparam logic [PW-1:0] MAX_LEN_P  = PW'(MAX_LEN);

  // Configuration registers
  logic [CFG_DATA_W-1:0] sep_chars_r;
  logic [LIST_LEN_W-1:0] list_len_r;

  // Window state
  state_t        state_r, state_nxt;
  logic [EW-1:0] first_r, first_nxt;
  logic [EW-1:0] last_r, last_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  // Scan scratch
  logic [EW-1:0]     w_r, w_nxt;
  logic [EW-1:0]     nf_r, nf_nxt;
  logic              found_r, found_nxt;
  logic              sep_r, sep_nxt;
  logic [CHAR_W-1:0] want_r, want_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_index_r, res_index_nxt;

  // Output word register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;

  // Table RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic              in_acc;
  logic              load_ok;
  logic              is_sep;
  logic [EW-1:0]     eff_first;
  logic [EW-1:0]     eff_last;
  logic [PW-1:0]     eff_pos;
  logic [EW-1:0]     clamp_len;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.match_index = out_index_r;

  // Load words write straight into the table when in range; the rest drop.
  assign load_ok   = (int'(in_ch.entry_index) < NUM_ENTRIES) &&
                     (int'(in_ch.char_position) < MAX_LEN);
  assign ram_we    = in_acc && (in_ch.command == CMD_LOAD) && load_ok;
  assign ram_waddr = AW'(in_ch.entry_index) * ROW_STRIDE + AW'(in_ch.char_position);
  assign ram_raddr = AW'(w_r) * ROW_STRIDE + AW'(pos_r);

  smk_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.char_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Separator test: a zero slot is unused, slots beyond SEP_SLOTS are ignored.
  always_comb begin
    is_sep = 1'b0;
    for (int k = 0; k < SEP_MAX; k++) begin
      if ((k < SEP_SLOTS) && (sep_chars_r[8*k +: 8] != '0) &&
          (sep_chars_r[8*k +: 8] == in_ch.char_value)) begin
        is_sep = 1'b1;
      end
    end
  end

  // Clamp an oversized list length to the table size.
  assign clamp_len = (int'(list_len_r) > NUM_ENTRIES) ? ENTRIES_E : EW'(list_len_r);
  assign eff_first = in_ch.start_req ? '0 : first_r;
  assign eff_last  = in_ch.start_req ? clamp_len : last_r;
  assign eff_pos   = in_ch.start_req ? '0 : pos_r;

  always_comb begin
    state_nxt      = state_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    pos_nxt        = pos_r;
    w_nxt          = w_r;
    nf_nxt         = nf_r;
    found_nxt      = found_r;
    sep_nxt        = sep_r;
    want_nxt       = want_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.command == CMD_MATCH)) begin
          // A start request reopens the window over the whole list.
          first_nxt     = eff_first;
          last_nxt      = eff_last;
          pos_nxt       = eff_pos;
          res_index_nxt = '0;
          if (in_ch.char_value == '0) begin
            res_status_nxt = ST_STRING_END;
            state_nxt      = S_OUT;
          end else if (eff_pos >= MAX_LEN_P) begin
            res_status_nxt = ST_NOT_IN_LIST;
            state_nxt      = S_OUT;
          end else begin
            // A separator matches the entry terminator.
            sep_nxt   = is_sep;
            want_nxt  = is_sep ? '0 : in_ch.char_value;
            w_nxt     = eff_first;
            nf_nxt    = eff_first;
            found_nxt = 1'b0;
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        if (w_r < last_r) begin
          // Address the table byte for entry w at the current position.
          state_nxt = S_CMP;
        end else begin
          // Window exhausted: narrow if anything matched.
          if (found_r) begin
            first_nxt      = nf_r;
            pos_nxt        = pos_r + 1'b1;
            res_status_nxt = ST_CONTINUE;
          end else begin
            res_status_nxt = ST_NOT_IN_LIST;
          end
          state_nxt = S_OUT;
        end
      end

      S_CMP: begin
        if (ram_rdata == want_r) begin
          if (sep_r) begin
            // First terminated entry wins; window stays as it is.
            res_status_nxt = ST_MATCHED;
            res_index_nxt  = IDX_W'(w_r);
            state_nxt      = S_OUT;
          end else begin
            if (!found_r) begin
              nf_nxt = w_r;
            end
            found_nxt = 1'b1;
            w_nxt     = w_r + 1'b1;
            state_nxt = S_RD;
          end
        end else if (found_r) begin
          // Sorted table: the first miss after a hit closes the window.
          first_nxt      = nf_r;
          last_nxt       = w_r;
          pos_nxt        = pos_r + 1'b1;
          res_status_nxt = ST_CONTINUE;
          state_nxt      = S_OUT;
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = S_RD;
        end
      end

      S_OUT: begin
        // Hold until the output slot is free, then hand the word over.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= '0;
      last_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      sep_chars_r <= '0;
      list_len_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEPARATOR_CHARS: sep_chars_r <= cfg_wdata;
          CFG_LIST_LENGTH:     list_len_r  <= cfg_wdata[LIST_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    nf_r         <= nf_nxt;
    found_r      <= found_nxt;
    sep_r        <= sep_nxt;
    want_r       <= want_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

endmodule

`default_nettype wire
